// ===== sv/ssht_pkg.sv =====
// Shared constants, command and status codes, and the token type of the slot chain.
package ssht_pkg;

  // Table geometry
  localparam int BUCKET_COUNT     = 10;
  localparam int SLOTS_PER_BUCKET = 8;
  localparam int KEY_CHARS        = 10;

  // Bucket is the key length mod this value, then mod BUCKET_COUNT
  localparam int LenMod = 10;

  // Fixed key layout: ten bytes, character 0 in the low byte
  localparam int MaxChars = 10;
  localparam int KeyW     = 8 * MaxChars;
  localparam int LowW     = 64;
  localparam int HighW    = 16;
  localparam int LenW     = 4;

  localparam int BucketW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

  typedef logic [KeyW-1:0]    key_t;
  typedef logic [BucketW-1:0] bucket_t;

  // Command codes; the unused code behaves as a search
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // One command travelling down the slot chain
  typedef struct packed {
    logic       valid;
    logic [1:0] cmd;
    key_t       key;
    bucket_t    bucket;
    logic       done;
  } token_t;

endpackage

// ===== sv/string_set_hash_table.sv =====
// Top level of the string multiset: input stage, chain of slot cells, output register.
//
// Keeps a multiset of keys of up to KEY_CHARS characters in BUCKET_COUNT buckets of
// SLOTS_PER_BUCKET slots; the bucket is the key length mod 10, mod BUCKET_COUNT.
// Each command (insert, search, delete one copy) enters a chain of SLOTS_PER_BUCKET
// cells, cell s owning slot s of every bucket; while the output is not stalled, the
// command visits one cell per cycle, and the first free (insert) or first matching
// (search, delete) slot serves it. Its result beat passes the input stage, the cell
// registers in turn and the output register. Commands follow each other in the chain,
// so a new one is taken every cycle unless the output is stalled, and each sees the
// effect of all earlier ones. The whole chain holds while a result beat is stalled at
// the output; valid marks clear at reset and no clearing pass is needed.
module string_set_hash_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  command_i,
  input  logic [ssht_pkg::LowW-1:0]   key_chars_low_i,
  input  logic [ssht_pkg::HighW-1:0]  key_chars_high_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o
);
  import ssht_pkg::*;

  token_t tok [SLOTS_PER_BUCKET+1];
  logic   advance;
  logic   out_valid_q;
  logic [1:0] out_status_q;
  logic [1:0] status_d;

  // Move the chain unless a result beat is held at the output
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  ssht_norm u_norm (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .in_valid_i       (in_valid_i),
    .command_i        (command_i),
    .key_chars_low_i  (key_chars_low_i),
    .key_chars_high_i (key_chars_high_i),
    .tok_o            (tok[0])
  );

  for (genvar s = 0; s < SLOTS_PER_BUCKET; s++) begin : g_cell
    ssht_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .tok_i     (tok[s]),
      .tok_o     (tok[s+1])
    );
  end

  // Turn the finished token into a status code
  always_comb begin
    if (tok[SLOTS_PER_BUCKET].done) begin
      status_d = ST_OK;
    end else if (tok[SLOTS_PER_BUCKET].cmd == CMD_INSERT) begin
      status_d = ST_FULL;
    end else begin
      status_d = ST_ABSENT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
    end else if (advance) begin
      out_valid_q  <= tok[SLOTS_PER_BUCKET].valid;
      out_status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;

endmodule

// ===== sv/ssht_norm.sv =====
// Input stage: cut the key at its first zero byte, pick its bucket, register the token.
module ssht_norm (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic                  in_valid_i,
  input  logic [1:0]            command_i,
  input  logic [ssht_pkg::LowW-1:0]  key_chars_low_i,
  input  logic [ssht_pkg::HighW-1:0] key_chars_high_i,
  output ssht_pkg::token_t      tok_o
);
  import ssht_pkg::*;

  key_t    raw;
  key_t    key_d;
  logic    alive;
  logic [LenW-1:0] len;
  bucket_t bucket_d;
  token_t  tok_d;
  token_t  tok_q;

  assign raw = {key_chars_high_i, key_chars_low_i};

  // Keep characters up to the first zero byte or the character limit
  always_comb begin
    key_d = '0;
    alive = 1'b1;
    len   = '0;
    for (int i = 0; i < MaxChars; i++) begin
      if (alive && (i < KEY_CHARS) && (raw[8*i +: 8] != 8'd0)) begin
        key_d[8*i +: 8] = raw[8*i +: 8];
        len = len + LenW'(1);
      end else begin
        alive = 1'b0;
      end
    end
  end

  // Map length to bucket through a small table
  always_comb begin
    bucket_d = '0;
    for (int j = 0; j <= MaxChars; j++) begin
      if (len == LenW'(j)) begin
        bucket_d = BucketW'((j % LenMod) % BUCKET_COUNT);
      end
    end
  end

  always_comb begin
    tok_d.valid  = in_valid_i;
    tok_d.cmd    = command_i;
    tok_d.key    = key_d;
    tok_d.bucket = bucket_d;
    tok_d.done   = 1'b0;
  end

  // Capture the beat whenever the chain moves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (advance_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== sv/ssht_cell.sv =====
// One slot position: holds that slot of every bucket and serves each passing command.
module ssht_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  ssht_pkg::token_t tok_i,
  output ssht_pkg::token_t tok_o
);
  import ssht_pkg::*;

  logic [BUCKET_COUNT-1:0] slot_valid_q;
  key_t                    slot_key_q [BUCKET_COUNT];

  logic   slot_v;
  logic   hit;
  logic   act;
  logic   do_ins;
  logic   do_del;
  logic   do_find;
  token_t tok_d;
  token_t tok_q;

  // Look at this cell's slot of the command's bucket
  always_comb begin
    slot_v  = slot_valid_q[tok_i.bucket];
    hit     = slot_v && (slot_key_q[tok_i.bucket] == tok_i.key);
    act     = tok_i.valid && !tok_i.done;
    do_ins  = act && (tok_i.cmd == CMD_INSERT) && !slot_v;
    do_del  = act && (tok_i.cmd == CMD_DELETE) && hit;
    do_find = act && (tok_i.cmd != CMD_INSERT) && hit;
    tok_d      = tok_i;
    tok_d.done = tok_i.done | do_ins | do_find;
  end

  // Pass the token on and update the valid marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q        <= '0;
      slot_valid_q <= '0;
    end else if (advance_i) begin
      tok_q <= tok_d;
      if (do_ins) begin
        slot_valid_q[tok_i.bucket] <= 1'b1;
      end else if (do_del) begin
        slot_valid_q[tok_i.bucket] <= 1'b0;
      end
    end
  end

  // Store the key of an insert
  always_ff @(posedge clk_i) begin
    if (advance_i && do_ins) begin
      slot_key_q[tok_i.bucket] <= tok_i.key;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== sv/ssht_checker.sv =====
// Port-level checks of the string multiset and their binding to the top level.
module ssht_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o
);
  import ssht_pkg::*;

  // Stall the input only behind a held result beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result beat");

  // No result beat right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat present right after reset");

  // Held result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // Held status does not change
  a_status_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(status_o))
    else $error("status changed while stalled");

endmodule

bind string_set_hash_table ssht_checker u_ssht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o)
);
